### hw/rtl/plate_speed_and_length_meter_top_defines.svh
// ---------------------------------------------------------------------------
// Plate meter assertion macros
// Shared concurrent assertion forms for the plate meter RTL.
// ---------------------------------------------------------------------------
`ifndef PLATE_SPEED_AND_LENGTH_METER_TOP_DEFINES_SVH
`define PLATE_SPEED_AND_LENGTH_METER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PSLM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plate meter check failed");

// antecedent implies consequent in the next cycle
`define PSLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plate meter check failed");

`endif

### hw/rtl/pslm_pkg.sv
// ---------------------------------------------------------------------------
// Plate meter package
// Shared constants, types and helper functions.
// ---------------------------------------------------------------------------
package pslm_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int DVSR_W         = 21;

   localparam logic [19:0] DLY_CAP = 20'd600000;
   localparam logic [19:0] LEN_MAX = 20'd1048575;
   localparam logic [23:0] SPD_NUM = 24'd15060000;
   localparam logic [14:0] RPM_MAX = 15'd32767;
   localparam int          SPD_ITERS = 24;

   localparam logic [2:0] CSR_TICK    = 3'd0;
   localparam logic [2:0] CSR_MFACT   = 3'd1;
   localparam logic [2:0] CSR_DEB     = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT = 3'd3;
   localparam logic [2:0] CSR_MINPER  = 3'd4;
   localparam logic [2:0] CSR_MAXLEN  = 3'd5;

   typedef struct packed {
      logic              start;
      logic [DVSR_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef struct packed {
      logic [19:0] tmr;
      logic        run;
      logic        store;
      logic [15:0] val;
   } dly_type;

   // x / 10 by reciprocal, exact for x < 655360
   function automatic logic [15:0] div10(logic [19:0] x);
      logic [39:0] p;
      p = x * 20'd838861;
      return p[38:23];
   endfunction

   function automatic dly_type dly_step(logic [19:0] tmr, logic run, logic start,
                                        logic edg, logic [6:0] tick);
      dly_type     r;
      logic [20:0] s;
      r.tmr   = tmr;
      r.run   = run;
      r.store = 1'b0;
      r.val   = '0;
      s = {1'b0, tmr} + 21'(tick);
      if (start && !run) begin
         r.run = 1'b1;
         r.tmr = '0;
      end else if (run) begin
         r.tmr = (s >= {1'b0, DLY_CAP}) ? DLY_CAP : s[19:0];
      end
      if (r.run && (edg || r.tmr >= DLY_CAP)) begin
         r.store = 1'b1;
         r.val   = div10(r.tmr);
         r.run   = 1'b0;
         r.tmr   = '0;
      end
      return r;
   endfunction

endpackage

### hw/rtl/plate_speed_and_length_meter_top.sv
// ---------------------------------------------------------------------------
// Plate speed and length meter
// One item per control tick: drive pulse and plate sensor levels in; speed,
// motor rpm and last plate length out, one result item per input item.
//
// req_*: input items (tdata[0] pulse level, tdata[1] sensor level).
// rsp_*: result items; tuser flags a freshly measured length.
// csr_*: register writes (index, data), always ready; write only when idle.
// Timing: one item in flight. Tick state updates on accept, then a shared
// bit-serial divider runs for speed and then for rpm; rpm is skipped with a
// zero motor factor and both with an invalid period. A plate trailing edge
// adds the product, numerator, scale and sum steps and a length division.
// req_tready is high while the sequencer is idle; a finished result waits in
// the output register, so the next item is taken while rsp is stalled, and
// its own result waits until the register drains.
// Reset: synchronous; clears control, tick and hold state, loads register defaults.
// ---------------------------------------------------------------------------
`include "plate_speed_and_length_meter_top_defines.svh"

module plate_speed_and_length_meter_top import pslm_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pulse_level, sensor_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // speed_milli, motor_rpm, length_centi
   output logic        rsp_tuser,   // length_new
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int PROD_W = COUNT_BITS + 16;
   localparam int NUM_W  = COUNT_BITS + 17;
   localparam int SCL_W  = COUNT_BITS + 32;
   localparam int CNT_W  = $clog2(SCL_W + 1);
   localparam int SPD_SH = SCL_W - SPD_ITERS;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SPD_GO  = 4'd1;
   localparam logic [3:0] ST_SPD_W   = 4'd2;
   localparam logic [3:0] ST_RPM_W   = 4'd3;
   localparam logic [3:0] ST_LEN_GO  = 4'd4;
   localparam logic [3:0] ST_LEN_NUM = 4'd5;
   localparam logic [3:0] ST_LEN_SCL = 4'd6;
   localparam logic [3:0] ST_LEN_SUM = 4'd7;
   localparam logic [3:0] ST_LEN_W   = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   // registers
   logic [6:0]  tick_ff;
   logic [15:0] mfact_ff;
   logic [9:0]  deb_ff;
   logic [15:0] timeout_ff;
   logic [9:0]  minper_ff;
   logic [13:0] maxlen_ff;

   // tick state
   logic                  pulse_prev_ff, pulse_prev_in;
   logic [15:0]           ptimer_ff, ptimer_in;
   logic [15:0]           period_ff, period_in;
   logic [13:0]           on_dly_ff, on_dly_in;
   logic [13:0]           off_dly_ff, off_dly_in;
   logic                  on_prev_ff, on_prev_in;
   logic                  off_prev_ff, off_prev_in;
   logic [19:0]           lead_tmr_ff, trail_tmr_ff;
   logic                  lead_run_ff, trail_run_ff;
   logic [15:0]           lead_dly_ff, lead_dly_in;
   logic [15:0]           trail_dly_ff, trail_dly_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  cen_ff, cen_in;
   logic [14:0]           rpm_hold_ff;
   logic [19:0]           len_hold_ff;

   // sequencer
   logic [3:0]            state_ff, state_in;
   logic                  valid_ff, valid_in;
   logic                  fall_ff, fall_in;
   logic [COUNT_BITS-1:0] lcnt_ff;
   logic [15:0]           speed_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [NUM_W-1:0]      num_ff;
   logic                  neg_ff;
   logic [SCL_W-1:0]      sa_ff, sb_ff;
   logic                  rsp_valid_ff;
   logic [55:0]           rsp_data_ff;
   logic                  rsp_user_ff;

   logic        accept, pedge, sensor;
   logic [16:0] tsum;
   logic [15:0] tsat;
   logic [13:0] deb_cap;
   logic [14:0] dsum;
   logic        on_q, off_q, rise;
   dly_type     lead_r, trail_r;
   logic [20:0] per17;
   logic [20:0] max_centi;
   logic [NUM_W-1:0] pos, neg;

   div_ctl_type       div_ctl;
   div_sts_type       div_sts;
   logic [SCL_W-1:0]  div_dvd;
   logic [CNT_W-1:0]  div_iters;
   logic [SCL_W-1:0]  div_q;
   logic [DVSR_W-1:0] div_r;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign sensor     = req_tdata[1];
   assign per17      = {period_ff, 4'b0} + 21'(period_ff);
   assign max_centi  = 21'(maxlen_ff) * 21'd100;

   // per-tick state update
   always_comb begin
      pedge         = req_tdata[0] & ~pulse_prev_ff;
      pulse_prev_in = req_tdata[0];
      tsum          = {1'b0, ptimer_ff} + 17'(tick_ff);
      tsat          = (tsum >= {1'b0, timeout_ff}) ? timeout_ff : tsum[15:0];
      if (pedge) begin
         period_in = tsat;
         ptimer_in = '0;
      end else begin
         period_in = period_ff;
         ptimer_in = tsat;
      end
      if (tsat >= timeout_ff) period_in = '0;
      valid_in = (period_in != '0) && (period_in >= 16'(minper_ff));

      deb_cap    = 14'(deb_ff) * 14'd10;
      on_dly_in  = on_dly_ff;
      off_dly_in = off_dly_ff;
      if (sensor) begin
         dsum       = {1'b0, on_dly_ff} + 15'(tick_ff);
         on_dly_in  = (dsum >= {1'b0, deb_cap}) ? deb_cap : dsum[13:0];
         on_q       = on_dly_in >= deb_cap;
         off_dly_in = '0;
         off_q      = 1'b1;
      end else begin
         dsum      = {1'b0, off_dly_ff} + 15'(tick_ff);
         on_dly_in = '0;
         on_q      = 1'b0;
         if (off_prev_ff) begin
            off_dly_in = (dsum >= {1'b0, deb_cap}) ? deb_cap : dsum[13:0];
            off_q      = off_dly_in < deb_cap;
         end else begin
            off_q = 1'b0;
         end
      end
      rise        = on_q && !on_prev_ff;
      fall_in     = !off_q && off_prev_ff;
      on_prev_in  = on_q;
      off_prev_in = off_q;

      lead_r       = dly_step(lead_tmr_ff, lead_run_ff, rise, pedge, tick_ff);
      trail_r      = dly_step(trail_tmr_ff, trail_run_ff, fall_in, pedge, tick_ff);
      lead_dly_in  = lead_r.store ? lead_r.val : lead_dly_ff;
      trail_dly_in = trail_r.store ? trail_r.val : trail_dly_ff;

      cen_in   = cen_ff;
      count_in = count_ff;
      if (fall_in) cen_in = 1'b0;
      if (rise) begin
         cen_in   = 1'b1;
         count_in = '0;
      end
      if (!on_q && !off_q) cen_in = 1'b0;
      if (cen_in && pedge && count_in != {COUNT_BITS{1'b1}})
         count_in = count_in + 1'b1;
   end

   // sequencer and divider feed
   always_comb begin
      state_in          = state_ff;
      div_ctl.start     = 1'b0;
      div_ctl.divisor   = per17;
      div_dvd           = {SPD_NUM, {SPD_SH{1'b0}}};
      div_iters         = CNT_W'(SPD_ITERS);
      pos = NUM_W'(prod_ff) + (valid_ff ? NUM_W'({lead_dly_ff, 3'b0}) +
                                          NUM_W'({lead_dly_ff, 1'b0}) : '0);
      neg = valid_ff ? NUM_W'({trail_dly_ff, 3'b0}) + NUM_W'({trail_dly_ff, 1'b0}) : '0;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_SPD_GO;
         ST_SPD_GO: begin
            if (valid_ff) begin
               div_ctl.start = 1'b1;
               state_in      = ST_SPD_W;
            end else begin
               state_in = ST_LEN_GO;
            end
         end
         ST_SPD_W: begin
            if (div_sts.done) begin
               if (mfact_ff == '0) begin
                  state_in = ST_LEN_GO;
               end else begin
                  div_ctl.start   = 1'b1;
                  div_ctl.divisor = DVSR_W'(mfact_ff);
                  div_dvd         = {div_q[23:0], {SPD_SH{1'b0}}};
                  state_in        = ST_RPM_W;
               end
            end
         end
         ST_RPM_W:   if (div_sts.done) state_in = ST_LEN_GO;
         ST_LEN_GO:  state_in = fall_ff ? ST_LEN_NUM : ST_DONE;
         ST_LEN_NUM: state_in = ST_LEN_SCL;
         ST_LEN_SCL: state_in = ST_LEN_SUM;
         ST_LEN_SUM: begin
            div_ctl.start   = 1'b1;
            div_ctl.divisor = valid_ff ? per17 : DVSR_W'(17);
            div_dvd         = sa_ff + sb_ff;
            div_iters       = CNT_W'(SCL_W);
            state_in        = ST_LEN_W;
         end
         ST_LEN_W:   if (div_sts.done) state_in = ST_DONE;
         ST_DONE:    if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   pslm_div #(
      .DIV_W (SCL_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dvd),
      .iters     (div_iters),
      .sts       (div_sts),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= 7'd10;
         mfact_ff      <= 16'd1000;
         deb_ff        <= 10'd100;
         timeout_ff    <= 16'd10000;
         minper_ff     <= 10'd50;
         maxlen_ff     <= 14'd3000;
         pulse_prev_ff <= 1'b0;
         ptimer_ff     <= '0;
         period_ff     <= '0;
         on_dly_ff     <= '0;
         off_dly_ff    <= '0;
         on_prev_ff    <= 1'b0;
         off_prev_ff   <= 1'b0;
         lead_tmr_ff   <= '0;
         trail_tmr_ff  <= '0;
         lead_run_ff   <= 1'b0;
         trail_run_ff  <= 1'b0;
         lead_dly_ff   <= '0;
         trail_dly_ff  <= '0;
         count_ff      <= '0;
         cen_ff        <= 1'b0;
         rpm_hold_ff   <= '0;
         len_hold_ff   <= '0;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TICK:    tick_ff    <= csr_data[6:0];
               CSR_MFACT:   mfact_ff   <= csr_data;
               CSR_DEB:     deb_ff     <= csr_data[9:0];
               CSR_TIMEOUT: timeout_ff <= csr_data;
               CSR_MINPER:  minper_ff  <= csr_data[9:0];
               CSR_MAXLEN:  maxlen_ff  <= csr_data[13:0];
               default: ;
            endcase
         end
         if (accept) begin
            pulse_prev_ff <= pulse_prev_in;
            ptimer_ff     <= ptimer_in;
            period_ff     <= period_in;
            on_dly_ff     <= on_dly_in;
            off_dly_ff    <= off_dly_in;
            on_prev_ff    <= on_prev_in;
            off_prev_ff   <= off_prev_in;
            lead_tmr_ff   <= lead_r.tmr;
            lead_run_ff   <= lead_r.run;
            trail_tmr_ff  <= trail_r.tmr;
            trail_run_ff  <= trail_r.run;
            lead_dly_ff   <= lead_dly_in;
            trail_dly_ff  <= trail_dly_in;
            count_ff      <= count_in;
            cen_ff        <= cen_in;
         end
         if (state_ff == ST_SPD_W && div_sts.done && mfact_ff == '0)
            rpm_hold_ff <= RPM_MAX;
         if (state_ff == ST_RPM_W && div_sts.done)
            rpm_hold_ff <= (div_q > SCL_W'(RPM_MAX)) ? RPM_MAX : div_q[14:0];
         if (state_ff == ST_LEN_W && div_sts.done) begin
            if (neg_ff || div_q > SCL_W'(max_centi) || div_q > SCL_W'(LEN_MAX) ||
                (div_q == SCL_W'(max_centi) && div_r != '0))
               len_hold_ff <= '0;
            else
               len_hold_ff <= div_q[19:0];
         end
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end

      if (accept) begin
         valid_ff <= valid_in;
         fall_ff  <= fall_in;
         lcnt_ff  <= count_ff;
         speed_ff <= '0;
      end
      if (state_ff == ST_SPD_W && div_sts.done) begin
         speed_ff <= (div_q > SCL_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
      end
      if (state_ff == ST_LEN_GO)
         prod_ff <= valid_ff ? PROD_W'(lcnt_ff) * PROD_W'(period_ff) : PROD_W'(lcnt_ff);
      if (state_ff == ST_LEN_NUM) begin
         neg_ff <= pos < neg;
         num_ff <= pos - neg;
      end
      if (state_ff == ST_LEN_SCL) begin
         sa_ff <= (SCL_W'(num_ff) << 14) + (SCL_W'(num_ff) << 13);
         sb_ff <= (SCL_W'(num_ff) << 9) + (SCL_W'(num_ff) << 3) + (SCL_W'(num_ff) << 2);
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {5'b0, len_hold_ff, rpm_hold_ff, speed_ff};
         rsp_user_ff <= fall_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `PSLM_ASSERT_SAME(a_div_no_restart, clock, reset, div_ctl.start, !div_sts.busy)
   `PSLM_ASSERT_NEXT(a_one_in_flight, clock, reset, accept, !req_tready)
   `PSLM_ASSERT_SAME(a_speed_invalid, clock, reset, state_ff == ST_DONE && !valid_ff, speed_ff == '0)

endmodule

### hw/rtl/pslm_div.sv
// ---------------------------------------------------------------------------
// Plate meter serial divider
// Restoring divider, one quotient bit per cycle, dividend top-aligned.
// ---------------------------------------------------------------------------
module pslm_div import pslm_pkg::*; #(
   parameter int DIV_W = COUNT_BITS_DEF + 32,
   parameter int CNT_W = $clog2(COUNT_BITS_DEF + 33)
) (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [CNT_W-1:0]  iters,
   output div_sts_type       sts,
   output logic [DIV_W-1:0]  quotient,
   output logic [DVSR_W-1:0] remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [DVSR_W:0]   trial;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, num_ff[DIV_W-1]};
      ge      = trial >= {1'b0, dvsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         num_in  = dividend;
         rem_in  = '0;
         dvsr_in = ctl.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DVSR_W'(trial - {1'b0, dvsr_ff}) : trial[DVSR_W-1:0];
         num_in = {num_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

### tb/plate_speed_and_length_meter_checker.sv
// ---------------------------------------------------------------------------
// Plate meter result checker
// Watches register writes, accepted ticks and accepted results. Each tick is
// run through a local model of the meter; each result, pad bits included, is
// compared with the oldest prediction. Mismatches and strays are counted.
// ---------------------------------------------------------------------------
module plate_speed_and_length_meter_checker import pslm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          pending,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64;

   typedef struct packed {
      logic [15:0] speed;
      logic [14:0] rpm;
      logic [19:0] len;
      logic        len_new;
   } meter_out_t;

   typedef struct {
      u64 tmr;
      bit run;
      u64 dly;
   } edge_timer_t;

   meter_out_t expected_q[$];

   u64 tick_ms, mfact, deb, tmo, minper, maxlen;
   bit pulse_prev, deb_on_prev, deb_off_prev, count_en;
   u64 per_tmr, period, on_ms, off_ms, pcount, rpm_hold, len_hold;
   edge_timer_t lead, trail;

   assign pending = expected_q.size();

   function automatic u64 sat_add(u64 a, u64 b, u64 cap);
      return (a + b >= cap) ? cap : a + b;
   endfunction

   function automatic edge_timer_t edge_timer(edge_timer_t st, bit start, bit pe, u64 tk);
      if (start && !st.run) begin
         st.run = 1;
         st.tmr = 0;
      end else if (st.run) begin
         st.tmr = sat_add(st.tmr, tk, 600000);
      end
      if (st.run && (pe || st.tmr >= 600000)) begin
         st.dly = st.tmr / 10;
         st.run = 0;
         st.tmr = 0;
      end
      return st;
   endfunction

   task automatic clear_meter();
      tick_ms = 10; mfact = 1000; deb = 100; tmo = 10000; minper = 50; maxlen = 3000;
      pulse_prev = 0; per_tmr = 0; period = 0; on_ms = 0; off_ms = 0;
      deb_on_prev = 0; deb_off_prev = 0; count_en = 0; pcount = 0;
      lead = '{0, 0, 0}; trail = '{0, 0, 0};
      rpm_hold = 0; len_hold = 0;
   endtask

   task automatic predict_tick(input bit pulse, input bit sensor, output meter_out_t r);
      bit pedge, valid, on_q, off_q, rise, fall;
      u64 t, q, rr, speed, deb_cap, den, len;
      longint num;
      pedge = pulse && !pulse_prev;
      pulse_prev = pulse;
      speed = 0;
      deb_cap = deb * 10;
      t = sat_add(per_tmr, tick_ms, tmo);
      if (pedge) begin
         period = t;
         per_tmr = 0;
      end else begin
         per_tmr = t;
      end
      if (t >= tmo) period = 0;
      valid = period != 0 && period >= minper;
      if (valid) begin
         q = 15060000 / (17 * period);
         speed = q > 65535 ? 65535 : q;
         if (mfact == 0) rr = 32767;
         else begin
            rr = q / mfact;
            if (rr > 32767) rr = 32767;
         end
         rpm_hold = rr;
      end
      if (sensor) begin
         on_ms = sat_add(on_ms, tick_ms, deb_cap);
         on_q = on_ms >= deb_cap;
         off_ms = 0;
         off_q = 1;
      end else begin
         on_ms = 0;
         on_q = 0;
         if (deb_off_prev) begin
            off_ms = sat_add(off_ms, tick_ms, deb_cap);
            off_q = off_ms < deb_cap;
         end else begin
            off_q = 0;
         end
      end
      rise = on_q && !deb_on_prev;
      fall = !off_q && deb_off_prev;
      deb_on_prev = on_q;
      deb_off_prev = off_q;
      lead = edge_timer(lead, rise, pedge, tick_ms);
      trail = edge_timer(trail, fall, pedge, tick_ms);
      if (fall) begin
         if (valid) begin
            num = longint'(pcount * period) + 10 * longint'(lead.dly)
                  - 10 * longint'(trail.dly);
            den = 17 * period;
         end else begin
            num = longint'(pcount);
            den = 17;
         end
         if (num < 0) len = 0;
         else if (25100 * u64'(num) > maxlen * 100 * den) len = 0;
         else begin
            len = 25100 * u64'(num) / den;
            if (len > 1048575) len = 0;
         end
         len_hold = len;
         count_en = 0;
      end
      if (rise) begin
         count_en = 1;
         pcount = 0;
      end
      if (!on_q && !off_q) count_en = 0;
      if (count_en && pedge && pcount < 65535) pcount++;
      r.speed = speed[15:0];
      r.rpm = rpm_hold[14:0];
      r.len = len_hold[19:0];
      r.len_new = fall;
   endtask

   initial begin
      fail_count = 0;
      clear_meter();
   end

   always @(posedge clock) begin
      meter_out_t e, a;
      if (reset) begin
         clear_meter();
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICK:    tick_ms = csr_data[6:0];
               CSR_MFACT:   mfact = csr_data;
               CSR_DEB:     deb = csr_data[9:0];
               CSR_TIMEOUT: tmo = csr_data;
               CSR_MINPER:  minper = csr_data[9:0];
               CSR_MAXLEN:  maxlen = csr_data[13:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata[0], req_tdata[1], e);
            expected_q.push_back(e);
         end
         if (rsp_tvalid && rsp_tready) begin
            a = '{rsp_tdata[15:0], rsp_tdata[30:16], rsp_tdata[50:31], rsp_tuser};
            if (expected_q.size() == 0) begin
               $display("%t: unexpected result %p", $realtime, a);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (a !== e || rsp_tdata[55:51] !== 5'd0) begin
                  $display("%t: mismatch expected %p actual %p (pad %h)",
                           $realtime, e, a, rsp_tdata[55:51]);
                  fail_count++;
               end
            end
         end
      end
   end

   final begin
      if (expected_q.size() != 0)
         $display("%0d results never arrived", expected_q.size());
   end
endmodule

### tb/tb_plate_speed_and_length_meter_top.sv
// ---------------------------------------------------------------------------
// Plate meter testbench
// Drives tick items under several register settings: a short directed
// sequence, then random pulse trains and plate passages with sensor noise.
// Sender bursts and receiver stalls are random, with one long receiver hold.
// ---------------------------------------------------------------------------
module tb_plate_speed_and_length_meter_top;
   import pslm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   int          pending, fail_count;
   int          burst_left;
   int          rx_cycle, rx_hold;

   plate_speed_and_length_meter_top DUT (.*);

   plate_speed_and_length_meter_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_plate_speed_and_length_meter_top NOT OK");
      $finish;
   end

   // receiver: random stalls, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rx_cycle <= 0;
         rx_hold <= 0;
         rsp_tready <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle == 3000) begin
            rx_hold <= 600;
            rsp_tready <= 0;
         end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            rsp_tready <= 0;
         end else if (rx_cycle[10:9] == 2'b01) begin
            rsp_tready <= 1;
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic send_tick(input bit pulse, input bit sensor);
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= {6'd0, sensor, pulse};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] v[6]);
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1;
         csr_index <= 3'(i);
         csr_data <= v[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic run_random(input int n, input int half_max, input int run_max);
      bit p, s;
      int p_cnt, s_cnt;
      p = 0; s = 0; p_cnt = 1; s_cnt = 1;
      for (int k = 0; k < n; k++) begin
         if (--p_cnt <= 0) begin
            p = ~p;
            p_cnt = ($urandom_range(0, 40) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, half_max);
         end
         if (--s_cnt <= 0) begin
            s = ~s;
            s_cnt = $urandom_range(1, run_max);
         end
         send_tick(p ^ ($urandom_range(0, 30) == 0), s ^ ($urandom_range(0, 12) == 0));
      end
   endtask

   logic [15:0] cfg_set[6][6] = '{
      '{16'd10, 16'd1000, 16'd100, 16'd10000, 16'd50, 16'd3000},
      '{16'd10, 16'd1000, 16'd2, 16'd10000, 16'd20, 16'd3000},
      '{16'd1, 16'd0, 16'd1, 16'd100, 16'd5, 16'd1},
      '{16'd100, 16'd65535, 16'd1000, 16'd60000, 16'd1000, 16'd10000},
      '{16'd0, 16'd7, 16'd0, 16'd65535, 16'd1023, 16'd16383},
      '{16'd127, 16'd1, 16'd3, 16'd200, 16'd20, 16'd3000}
   };
   int half_set[6] = '{4, 4, 15, 3, 5, 2};
   int run_set[6] = '{250, 60, 40, 250, 30, 20};
   int len_set[6] = '{200, 250, 200, 200, 100, 180};

   bit [1:0] directed[24] = '{
      2'b10, 2'b10, 2'b11, 2'b10, 2'b11, 2'b10, 2'b11, 2'b11, 2'b10, 2'b10,
      2'b11, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b10, 2'b11, 2'b10,
      2'b01, 2'b00, 2'b00, 2'b01
   };

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      rsp_tready = 0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_regs(cfg_set[1]);
      foreach (directed[k]) send_tick(directed[k][0], directed[k][1]);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_regs(cfg_set[ph]);
         run_random(len_set[ph], half_set[ph], run_set[ph]);
         drain();
      end

      if (fail_count == 0) begin
         $display("tb_plate_speed_and_length_meter_top OK");
      end else begin
         $display("tb_plate_speed_and_length_meter_top NOT OK");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pslm_pkg.sv
hw/rtl/pslm_div.sv
hw/rtl/plate_speed_and_length_meter_top.sv
tb/plate_speed_and_length_meter_checker.sv
tb/tb_plate_speed_and_length_meter_top.sv
